// ===== rtl/kmd_pkg.sv =====
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared constants and types for the key matrix debounce event unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kmd_pkg;

    localparam int ROW_COUNT    = 3;
    localparam int COLUMN_COUNT = 5;
    localparam int KEY_LIMIT    = 15;
    localparam int KEY_TOTAL    = ROW_COUNT * COLUMN_COUNT;
    localparam int KEY_COUNT    = (KEY_TOTAL < KEY_LIMIT) ? KEY_TOTAL : KEY_LIMIT;
    localparam int KEY_W        = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    localparam int BITS_W     = 15;
    localparam int TIME_W     = 32;
    localparam int DEB_W      = 16;
    localparam int IDX_W      = 4;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;

    typedef struct packed {
        logic              upd_raw;
        logic              upd_deb;
        logic [KEY_W-1:0]  idx;
        logic              level;
        logic [TIME_W-1:0] now;
    } kmd_wr_t;

    typedef struct packed {
        logic              raw;
        logic              deb;
        logic [TIME_W-1:0] change_time;
    } kmd_rd_t;

endpackage

`default_nettype wire

// ===== rtl/kmd_stable_cmp.sv =====
// ----------------------------------------------------------------------------
// kmd_stable_cmp
// Shared elapsed-time unit: wrapped subtract and compare against debounce.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_stable_cmp (
    input  wire logic [kmd_pkg::TIME_W-1:0] now,
    input  wire logic [kmd_pkg::TIME_W-1:0] change_time,
    input  wire logic [kmd_pkg::DEB_W-1:0]  debounce_ms,
    output logic                            stable
);
    import kmd_pkg::*;

    logic [TIME_W-1:0] elapsed;

    assign elapsed = now - change_time;
    assign stable  = elapsed > {{(TIME_W-DEB_W){1'b0}}, debounce_ms};

endmodule

`default_nettype wire

// ===== rtl/kmd_key_state.sv =====
// ----------------------------------------------------------------------------
// kmd_key_state
// Per-key raw level, debounced level and change time storage.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_key_state (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [kmd_pkg::KEY_W-1:0] rd_idx,
    output kmd_pkg::kmd_rd_t            rd,
    input  wire kmd_pkg::kmd_wr_t       wr
);
    import kmd_pkg::*;

    logic [KEY_COUNT-1:0] raw_reg;
    logic [KEY_COUNT-1:0] deb_reg;
    logic [TIME_W-1:0]    time_reg [KEY_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg <= '0;
            deb_reg <= '0;
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                time_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.upd_raw)
            begin
                raw_reg[wr.idx]  <= wr.level;
                time_reg[wr.idx] <= wr.now;
            end
            if (wr.upd_deb)
            begin
                deb_reg[wr.idx] <= wr.level;
            end
        end
    end

    assign rd.raw         = raw_reg[rd_idx];
    assign rd.deb         = deb_reg[rd_idx];
    assign rd.change_time = time_reg[rd_idx];

endmodule

`default_nettype wire

// ===== rtl/key_matrix_debounce_events_unit.sv =====
// ----------------------------------------------------------------------------
// key_matrix_debounce_events_unit
// Debounces a scanned key matrix and emits press/release events per scan.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one item per full matrix scan (pressed bits and scan time in ms).
//   m_axis: one item per debounced state change, ascending key order; tlast
//           marks the final event of a scan. A quiet scan produces no item.
//   cfg:    debounce_ms write, taken any cycle (always ready); write only
//           while idle.
// Timing: a scan walks the keys one per cycle while the output does not
//   stall, through a single shared subtract/compare unit. s_axis_tready is
//   high only between scans, so a new scan is taken only after the last one
//   is done. One event is held back so that tlast can be set; the last
//   event is pushed in the flush state once the walk ends and the output
//   slot is free.
// Stall: if m_axis_tready is low while an event must be pushed, the key walk
//   pauses; nothing is lost.
// Reset: all keys released, change times zero, debounce_ms = 20.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debounce_events_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [14:0] key_pressed_bits, [46:15] now_ms, [47] zero
    input  wire logic [kmd_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [3:0] key_index, [4] pressed, [7:5] zero
    output logic [kmd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [kmd_pkg::DEB_W-1:0]     cfg_data
);
    import kmd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(KEY_COUNT - 1);

    logic [1:0]           state_reg, state_next;
    logic [KEY_W-1:0]     k_reg, k_next;
    logic [KEY_COUNT-1:0] bits_reg, bits_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [DEB_W-1:0]     deb_ms_reg;
    logic                 pend_valid_reg, pend_valid_next;
    logic [KEY_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                 pend_level_reg, pend_level_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     out_idx_reg, out_idx_next;
    logic                 out_pressed_reg, out_pressed_next;
    logic                 out_last_reg, out_last_next;

    kmd_rd_t rd;
    kmd_wr_t wr;
    logic    stable;
    logic    level;
    logic    differs;
    logic    key_event;
    logic    slot_free;
    logic    stall;
    logic    push;
    logic    push_last;

    kmd_key_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (k_reg),
        .rd     (rd),
        .wr     (wr)
    );

    kmd_stable_cmp u_cmp (
        .now         (now_reg),
        .change_time (rd.change_time),
        .debounce_ms (deb_ms_reg),
        .stable      (stable)
    );

    assign level     = bits_reg[k_reg];
    assign differs   = level != rd.raw;
    assign key_event = !differs && stable && (level != rd.deb);
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign stall     = key_event && pend_valid_reg && !slot_free;

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        bits_next       = bits_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_level_next = pend_level_reg;
        push            = 1'b0;
        push_last       = 1'b0;
        wr.upd_raw      = 1'b0;
        wr.upd_deb      = 1'b0;
        wr.idx          = k_reg;
        wr.level        = level;
        wr.now          = now_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    bits_next       = s_axis_tdata[KEY_COUNT-1:0];
                    now_next        = s_axis_tdata[BITS_W +: TIME_W];
                    k_next          = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    wr.upd_raw = differs;
                    wr.upd_deb = key_event;
                    if (key_event)
                    begin
                        push            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_idx_next   = k_reg;
                        pend_level_next = level;
                    end
                    if (k_reg == KEY_LAST)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_idx_next     = out_idx_reg;
        out_pressed_next = out_pressed_reg;
        out_last_next    = out_last_reg;
        if (push)
        begin
            out_valid_next   = 1'b1;
            out_idx_next     = IDX_W'(pend_idx_reg);
            out_pressed_next = pend_level_reg;
            out_last_next    = push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            deb_ms_reg     <= DEBOUNCE_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid)
            begin
                deb_ms_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg        <= bits_next;
        now_reg         <= now_next;
        pend_idx_reg    <= pend_idx_next;
        pend_level_reg  <= pend_level_next;
        out_idx_reg     <= out_idx_next;
        out_pressed_reg <= out_pressed_next;
        out_last_reg    <= out_last_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-IDX_W-1){1'b0}}, out_pressed_reg, out_idx_reg};

endmodule

`default_nettype wire

// ===== tb/kmd_event_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmd_event_checker
// Watches the scan, event and config channels of the debounce unit, keeps its
// own per-key debounce state, queues the events each accepted scan must cause
// and compares every accepted event field by field against the oldest one.
// ----------------------------------------------------------------------------

module kmd_event_checker
    import kmd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [DEB_W-1:0]      cfg_data,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [IDX_W-1:0] key;
        logic             pressed;
        logic             last;
    } key_event_t;

    key_event_t          events_due[$];
    key_event_t          want;
    logic [DEB_W-1:0]    hold_ms;
    logic [KEY_LIMIT-1:0] raw_seen;
    logic [KEY_LIMIT-1:0] stable_level;
    logic [TIME_W-1:0]   flip_time [KEY_LIMIT];
    int                  miss_total;

    function automatic void log_failure(input string what);
        miss_total++;
        if (miss_total <= 10)
            $display("%s", what);
    endfunction

    // Walk the keys in ascending order, queue one event per debounced change.
    function automatic void predict_scan(input logic [BITS_W-1:0] bits,
                                         input logic [TIME_W-1:0] now);
        key_event_t        ev;
        logic [TIME_W-1:0] age;
        int                n;
        n = 0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            if (bits[k] != raw_seen[k])
            begin
                flip_time[k] = now;
                raw_seen[k]  = bits[k];
            end
            else
            begin
                age = now - flip_time[k];
                if (age > TIME_W'(hold_ms) && bits[k] != stable_level[k])
                begin
                    stable_level[k] = bits[k];
                    ev.key     = IDX_W'(k);
                    ev.pressed = bits[k];
                    ev.last    = 1'b0;
                    events_due.push_back(ev);
                    n++;
                end
            end
        end
        if (n > 0)
        begin
            ev = events_due.pop_back();
            ev.last = 1'b1;
            events_due.push_back(ev);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms      = DEBOUNCE_RESET;
            raw_seen     = '0;
            stable_level = '0;
            for (int k = 0; k < KEY_LIMIT; k++)
                flip_time[k] = '0;
            events_due.delete();
            miss_total   = 0;
            fail_count  <= 0;
            pending     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (events_due.size() == 0)
                    log_failure($sformatf("unexpected event: key %0d pressed %0b last %0b",
                                          m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W],
                                          m_axis_tlast));
                else
                begin
                    want = events_due.pop_front();
                    if (m_axis_tdata[IDX_W-1:0] !== want.key
                        || m_axis_tdata[IDX_W] !== want.pressed
                        || m_axis_tlast !== want.last
                        || m_axis_tdata[OUT_DATA_W-1:IDX_W+1] !== '0)
                        log_failure($sformatf(
                            "event mismatch: key %0d/%0d pressed %0b/%0b last %0b/%0b pad 0/%0h (exp/act)",
                            want.key, m_axis_tdata[IDX_W-1:0], want.pressed,
                            m_axis_tdata[IDX_W], want.last, m_axis_tlast,
                            m_axis_tdata[OUT_DATA_W-1:IDX_W+1]));
                end
            end
            if (cfg_valid && cfg_ready)
                hold_ms = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                predict_scan(s_axis_tdata[BITS_W-1:0], s_axis_tdata[BITS_W +: TIME_W]);
            fail_count <= miss_total;
            pending    <= events_due.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives matrix scans and debounce settings into the key matrix debounce unit
// with random gaps and output stalls, including one long output hold-off, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------

module tb;
    import kmd_pkg::*;

    localparam int LIMIT        = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 22;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [DEB_W-1:0]      cfg_data = '0;

    int                    fail_count;
    int                    pending;
    int unsigned           cycle_count = 0;
    logic                  hold_req = 1'b0;
    logic                  steady = 1'b0;
    logic [TIME_W-1:0]     scan_ms = '0;

    key_matrix_debounce_events_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    kmd_event_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Event sink: random ready/stall runs, one long hold-off on request.
    initial
    begin : sink
        int   run_left;
        int   hold_left;
        int   r;
        logic held;
        logic rdy;
        run_left  = 0;
        hold_left = 0;
        held      = 1'b0;
        rdy       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy      = 1'b0;
                run_left = 0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (steady)
                    begin
                        rdy = 1'b1;
                        run_left = 20;
                    end
                    else if (r < 60)
                    begin
                        rdy = 1'b1;
                        run_left = $urandom_range(1, 8);
                    end
                    else if (r < 90)
                    begin
                        rdy = 1'b0;
                        run_left = $urandom_range(1, 3);
                    end
                    else if (r < 98)
                    begin
                        rdy = 1'b0;
                        run_left = $urandom_range(4, 12);
                    end
                    else
                    begin
                        rdy = 1'b0;
                        run_left = $urandom_range(30, 80);
                    end
                end
                run_left--;
            end
            m_axis_tready <= rdy;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void advance_clock(input logic [DEB_W-1:0] deb);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            scan_ms = $urandom();
        else if (r < 40)
            scan_ms += $urandom_range(0, int'(deb) / 2 + 2);
        else if (r < 70)
            scan_ms += int'(deb) + $urandom_range(0, 2);
        else
            scan_ms += $urandom_range(0, int'(deb) + 5);
    endfunction

    // Called at a clock edge; returns at the edge where the scan is taken.
    task automatic send_scan(input logic [BITS_W-1:0] bits, input logic [TIME_W-1:0] ms);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({ms, bits});
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_debounce(input logic [DEB_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly bounce-then-hold sequences toward a random key pattern, some noise.
    task automatic run_random(input logic [DEB_W-1:0] deb, input int n_items);
        int              sent;
        int              r;
        logic [BITS_W-1:0] goal;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                if ($urandom_range(0, 1))
                    scan_ms = $urandom();
                else
                    advance_clock(deb);
                send_scan(BITS_W'($urandom()), scan_ms);
                sent++;
            end
            else
            begin
                goal = BITS_W'($urandom_range(0, 32767));
                repeat ($urandom_range(0, 3))
                begin
                    advance_clock(deb);
                    send_scan(goal ^ BITS_W'($urandom() & $urandom()), scan_ms);
                    sent++;
                end
                repeat ($urandom_range(1, 4))
                begin
                    advance_clock(deb);
                    send_scan(goal, scan_ms);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        logic [DEB_W-1:0] phase_deb;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset debounce of 20 ms: boundary, all keys, single key, timer wrap
        send_scan(15'h0000, 32'd0);
        send_scan(15'h7FFF, 32'd5);
        send_scan(15'h7FFF, 32'd25);
        send_scan(15'h7FFF, 32'd26);
        send_scan(15'h0000, 32'd30);
        send_scan(15'h0000, 32'd51);
        send_scan(15'h4000, 32'd100);
        send_scan(15'h4000, 32'd121);
        send_scan(15'h0001, 32'hFFFF_FFF0);
        send_scan(15'h0001, 32'hFFFF_FFFF);
        send_scan(15'h0001, 32'd5);
        send_scan(15'h0002, 32'd10);
        send_scan(15'h0000, 32'd12);
        send_scan(15'h0002, 32'd14);
        send_scan(15'h0002, 32'd40);

        // zero debounce: equal scan times do not qualify
        set_debounce(16'd0);
        send_scan(15'h5555, 32'd200);
        send_scan(15'h5555, 32'd200);
        send_scan(15'h5555, 32'd201);

        set_debounce(16'hFFFF);
        send_scan(15'h2AAA, 32'd1000);
        send_scan(15'h2AAA, 32'd1000 + 32'd65535);
        send_scan(15'h2AAA, 32'd1000 + 32'd65536);
        send_scan(15'h0000, 32'hFFFF_FFFF);
        send_scan(15'h0000, 32'h0000_FFFF);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: phase_deb = 16'd20;
                1: phase_deb = 16'd0;
                2: phase_deb = 16'hFFFF;
                3: phase_deb = 16'd1;
                4: phase_deb = DEB_W'($urandom_range(0, 65535));
                default: phase_deb = DEB_W'($urandom_range(1, 50));
            endcase
            if (p == 2)
                scan_ms = 32'hFFFF_0000 + $urandom_range(0, 65535);
            set_debounce(phase_deb);
            if (p == 1)
                hold_req <= 1'b1;
            if (p == 3)
                steady <= 1'b1;
            run_random(phase_deb, PHASE_ITEMS);
            if (p == 3)
                steady <= 1'b0;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/kmd_pkg.sv
rtl/kmd_stable_cmp.sv
rtl/kmd_key_state.sv
rtl/key_matrix_debounce_events_unit.sv
tb/kmd_event_checker.sv
tb/tb.sv
